// ----- rtl/tcrb_pkg.sv -----
// Shared types and constants for the triggered capture ring buffer.
// No dependencies; every other file imports this package.
package tcrb_pkg;

  localparam int DEPTH      = 1024;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SAMPLE_W   = 16;
  localparam int WORD_W     = 4 * SAMPLE_W;
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_W      = 11;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [CFG_W-1:0] DEPTH_RESET   = CFG_W'(1024);
  localparam logic [CFG_W-1:0] PRETRIG_RESET = CFG_W'(512);

  typedef enum logic {
    REG_DEPTH   = 1'b0,
    REG_PRETRIG = 1'b1
  } reg_idx_t;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_READ   = 1'b1
  } func_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              done;
    logic              stopped;
    logic [ADDR_W-1:0] oldest;
  } ctrl_stat_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] start;
    logic [WORD_W-1:0] word;
  } res_item_t;

endpackage

// ----- rtl/tcrb_in_if.sv -----
// Request channel of the capture buffer: valid/ready plus request fields.
// Depends on tcrb_pkg for field widths.
interface tcrb_in_if import tcrb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic                       event_req;
  logic                       rearm;
  logic signed [SAMPLE_W-1:0] sample_0;
  logic signed [SAMPLE_W-1:0] sample_1;
  logic signed [SAMPLE_W-1:0] sample_2;
  logic signed [SAMPLE_W-1:0] sample_3;
  logic        [ADDR_W-1:0]   read_index;

  modport source (output valid, func, event_req, rearm, sample_0, sample_1, sample_2,
                  sample_3, read_index, input ready);
  modport sink (input valid, func, event_req, rearm, sample_0, sample_1, sample_2,
                sample_3, read_index, output ready);
endinterface

// ----- rtl/tcrb_out_if.sv -----
// Result channel of the capture buffer: valid/ready plus result fields.
// Depends on tcrb_pkg for field widths.
interface tcrb_out_if import tcrb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       done_res;
  logic        [ADDR_W-1:0]   read_start;
  logic signed [SAMPLE_W-1:0] data_0;
  logic signed [SAMPLE_W-1:0] data_1;
  logic signed [SAMPLE_W-1:0] data_2;
  logic signed [SAMPLE_W-1:0] data_3;

  modport source (output valid, done_res, read_start, data_0, data_1, data_2, data_3,
                  input ready);
  modport sink (input valid, done_res, read_start, data_0, data_1, data_2, data_3,
                output ready);
endinterface

// ----- rtl/tcrb_store.sv -----
// Sample store: one-write, one-read synchronous memory with registered read data.
// Depends on tcrb_pkg.
module tcrb_store import tcrb_pkg::*; (
  input  logic              clk,
  input  mem_wr_t           wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/tcrb_ctrl.sv -----
// Capture control: write pointer, fill level, trigger latch and stop logic.
// Issues store writes for sample requests. Depends on tcrb_pkg.
module tcrb_ctrl import tcrb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              rearm,
  input  logic              event_req,
  input  logic [WORD_W-1:0] sample_word,
  input  logic [CFG_W-1:0]  depth_cfg,
  input  logic [CFG_W-1:0]  pretrig_cfg,
  output mem_wr_t           wr,
  output ctrl_stat_t        stat,
  output ctrl_stat_t        res
);

  logic [ADDR_W-1:0] write_pointer, write_pointer_next;
  logic [CNT_W-1:0]  fill_count, fill_count_next;
  logic [CNT_W-1:0]  post_count, post_count_next;
  logic              latched, latched_next;
  logic              seen, seen_next;
  logic              stopped, stopped_next;
  logic              done_flag, done_next;
  logic [ADDR_W-1:0] oldest, oldest_next;

  logic [CNT_W-1:0]  depth;
  logic [CNT_W-1:0]  pre;
  logic [CNT_W-1:0]  wp_inc;
  logic [CNT_W:0]    stop_sum;
  logic              do_write;

  always_comb begin
    if (depth_cfg == '0) begin
      depth = CNT_W'(1);
    end else if (CNT_W'(depth_cfg) > CNT_W'(DEPTH)) begin
      depth = CNT_W'(DEPTH);
    end else begin
      depth = CNT_W'(depth_cfg);
    end
    pre = (CNT_W'(pretrig_cfg) > depth) ? depth : CNT_W'(pretrig_cfg);
  end

  always_comb begin
    write_pointer_next = write_pointer;
    fill_count_next    = fill_count;
    post_count_next    = post_count;
    latched_next       = latched;
    seen_next          = seen;
    stopped_next       = stopped;
    done_next          = done_flag;
    oldest_next        = oldest;
    do_write           = 1'b0;
    wp_inc             = CNT_W'(write_pointer) + CNT_W'(1);
    stop_sum           = '0;

    if (step) begin
      if (rearm) begin
        done_next       = 1'b0;
        stopped_next    = 1'b0;
        seen_next       = 1'b0;
        latched_next    = 1'b0;
        post_count_next = '0;
      end
      if (event_req) begin
        latched_next = 1'b1;
      end
      if (fill_count >= depth) begin
        oldest_next = write_pointer;
      end
      if (!stopped_next) begin
        if (latched_next) begin
          if (!seen_next) begin
            seen_next       = 1'b1;
            post_count_next = '0;
          end
          stop_sum = {1'b0, post_count_next} + {1'b0, pre};
          if (stop_sum >= {1'b0, depth}) begin
            done_next    = 1'b1;
            stopped_next = 1'b1;
            latched_next = 1'b0;
          end else begin
            do_write        = 1'b1;
            post_count_next = post_count_next + CNT_W'(1);
          end
        end else begin
          do_write = 1'b1;
        end
      end
      if (do_write) begin
        // Wrap at the depth in use; a pointer past a lowered depth wraps too.
        write_pointer_next = (wp_inc >= depth) ? '0 : wp_inc[ADDR_W-1:0];
        fill_count_next    = (fill_count < depth) ? fill_count + CNT_W'(1) : depth;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      fill_count    <= '0;
      post_count    <= '0;
      latched       <= 1'b0;
      seen          <= 1'b0;
      stopped       <= 1'b0;
      done_flag     <= 1'b0;
      oldest        <= '0;
    end else begin
      write_pointer <= write_pointer_next;
      fill_count    <= fill_count_next;
      post_count    <= post_count_next;
      latched       <= latched_next;
      seen          <= seen_next;
      stopped       <= stopped_next;
      done_flag     <= done_next;
      oldest        <= oldest_next;
    end
  end

  assign wr.en   = do_write;
  assign wr.addr = write_pointer;
  assign wr.data = sample_word;

  assign stat.done    = done_flag;
  assign stat.stopped = stopped;
  assign stat.oldest  = oldest;

  assign res.done    = done_next;
  assign res.stopped = stopped_next;
  assign res.oldest  = oldest_next;

endmodule

// ----- rtl/tcrb_out_fifo.sv -----
// Small result queue that decouples the memory read stage from the receiver.
// Depends on tcrb_pkg.
module tcrb_out_fifo import tcrb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  res_item_t             din,
  input  logic                  pop,
  output res_item_t             dout,
  output logic                  not_empty,
  output logic [FIFO_CNT_W-1:0] count
);

  res_item_t               entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

  assign dout      = entries[rd_ptr];
  assign not_empty = (count != '0);

endmodule

// ----- rtl/triggered_capture_ring_buffer_top.sv -----
// Triggered capture ring buffer, top level.
// Uses tcrb_pkg, tcrb_in_if, tcrb_out_if, tcrb_ctrl, tcrb_store, tcrb_out_fifo.
//
// Usage:
//   in_ch carries one request per valid/ready handshake: a sample step
//   (func = 0) stores four 16-bit channel samples at the write pointer unless
//   capture has stopped, and handles rearm and the trigger pulse; a read
//   (func = 1) fetches the entry at read_index. Every request yields exactly
//   one result on out_ch with done_res, read_start and, for reads, the stored
//   channels (zero for sample steps).
//   Each result passes the read stage, alongside the store's registered read
//   port, and then the result queue before it is offered. Throughput: one
//   request per cycle while the receiver keeps taking results; the store takes
//   one write or one read per cycle.
//   Reset (rst, synchronous) clears pointers, fill level, trigger and done
//   state and the result queue; store contents stay undefined until written.
//   depth_in_use (address 0) and pretrigger_count (address 4) return to 1024
//   and 512; the user writes them over the APB port while idle, unchecked by
//   the block. A stalled receiver fills a three-entry result queue; in_ch.ready
//   drops only when the queue and the read stage together hold three results.
module triggered_capture_ring_buffer_top import tcrb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  tcrb_in_if.sink            in_ch,
  tcrb_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [CFG_W-1:0]      depth_cfg;
  logic [CFG_W-1:0]      pretrig_cfg;
  reg_idx_t              reg_sel;
  logic                  cfg_write;

  logic                  accept;
  logic                  step;
  logic                  rd_en;
  logic [WORD_W-1:0]     sample_word;
  logic [WORD_W-1:0]     rd_data;
  mem_wr_t               wr;
  ctrl_stat_t            stat;
  ctrl_stat_t            res;

  logic                  s1_valid;
  logic                  s1_is_read;
  logic                  s1_done;
  logic [ADDR_W-1:0]     s1_start;
  res_item_t             fifo_din;
  res_item_t             fifo_dout;
  logic                  fifo_not_empty;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic                  pop;

  // Configuration port
  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_cfg   <= DEPTH_RESET;
      pretrig_cfg <= PRETRIG_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_DEPTH:   depth_cfg   <= pwdata[CFG_W-1:0];
        REG_PRETRIG: pretrig_cfg <= pwdata[CFG_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEPTH:   prdata = PDATA_W'(depth_cfg);
      REG_PRETRIG: prdata = PDATA_W'(pretrig_cfg);
      default:     prdata = '0;
    endcase
  end

  // Request side: take a request while the read stage plus queue have room.
  assign in_ch.ready = (FIFO_CNT_W'(s1_valid) + fifo_count) < FIFO_CNT_W'(FIFO_DEPTH);
  assign accept      = in_ch.valid && in_ch.ready;
  assign step        = accept && (func_t'(in_ch.func) == FUNC_SAMPLE);
  assign rd_en       = accept && (func_t'(in_ch.func) == FUNC_READ);
  assign sample_word = {in_ch.sample_3, in_ch.sample_2, in_ch.sample_1, in_ch.sample_0};

  tcrb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .rearm       (in_ch.rearm),
    .event_req   (in_ch.event_req),
    .sample_word (sample_word),
    .depth_cfg   (depth_cfg),
    .pretrig_cfg (pretrig_cfg),
    .wr          (wr),
    .stat        (stat),
    .res         (res)
  );

  tcrb_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (in_ch.read_index),
    .rd_data (rd_data)
  );

  // Read stage: line up the result fields with the registered read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_is_read <= rd_en;
      s1_done    <= res.done;
      s1_start   <= res.oldest;
    end
  end

  assign fifo_din.done  = s1_done;
  assign fifo_din.start = s1_start;
  assign fifo_din.word  = s1_is_read ? rd_data : '0;

  assign pop = out_ch.valid && out_ch.ready;

  tcrb_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .din       (fifo_din),
    .pop       (pop),
    .dout      (fifo_dout),
    .not_empty (fifo_not_empty),
    .count     (fifo_count)
  );

  assign out_ch.valid      = fifo_not_empty;
  assign out_ch.done_res   = fifo_dout.done;
  assign out_ch.read_start = fifo_dout.start;
  assign out_ch.data_0     = fifo_dout.word[0*SAMPLE_W +: SAMPLE_W];
  assign out_ch.data_1     = fifo_dout.word[1*SAMPLE_W +: SAMPLE_W];
  assign out_ch.data_2     = fifo_dout.word[2*SAMPLE_W +: SAMPLE_W];
  assign out_ch.data_3     = fifo_dout.word[3*SAMPLE_W +: SAMPLE_W];

  // The request credit must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (fifo_count != FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

  // A stopped capture writes nothing unless this request rearms it.
  a_no_write_stopped: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (!stat.stopped || in_ch.rearm))
    else $error("store written while capture stopped");

  // A store write only happens for an accepted sample request.
  a_write_on_step: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> step)
    else $error("store write without sample request");

endmodule
